[hw/rtl/cidp_pkg.sv]
// ----------------------------------------------------------------------------
// Caller-ID parser package
// Shared constants, result codes and the frame event type of the caller-ID
// message parser.
// ----------------------------------------------------------------------------
package cidp_pkg;

   // Default store sizes (characters)
   localparam int unsigned NUMBER_MAX_DEF = 24;
   localparam int unsigned NAME_MAX_DEF   = 24;

   // Framing bytes
   localparam logic [7:0] FLAG_BYTE   = 8'h55;
   localparam logic [7:0] LEADIN_SDMF = 8'h04;
   localparam logic [7:0] LEADIN_MDMF = 8'h80;

   // SDMF body index where the number starts
   localparam logic [7:0] SDMF_NUMBER_START = 8'd8;

   // MDMF parameter types
   localparam logic [7:0] PARAM_NUMBER_A = 8'd2;
   localparam logic [7:0] PARAM_NUMBER_B = 8'd4;
   localparam logic [7:0] PARAM_NAME_A   = 8'd7;
   localparam logic [7:0] PARAM_NAME_B   = 8'd8;

   // Result kinds
   localparam logic [1:0] KIND_NUMBER = 2'd0;
   localparam logic [1:0] KIND_NAME   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Frame status codes
   localparam logic [1:0] ST_GOOD_MDMF = 2'd0;
   localparam logic [1:0] ST_GOOD_SDMF = 2'd1;
   localparam logic [1:0] ST_BAD_SUM   = 2'd2;
   localparam logic [1:0] ST_RX_ERR    = 2'd3;

   // Frame end event from the parser to the readout sequencer
   typedef struct packed {
      logic       fire;    // frame ended on this transaction
      logic       good;    // checksum good: read out the stores
      logic [1:0] status;  // status code of the closing result
   } cidp_evt_type;

endpackage

[hw/rtl/cidp_if.sv]
// ----------------------------------------------------------------------------
// Caller-ID parser channels
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface cidp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       rx_error;

   modport source (output valid, output rx_byte, output rx_error, input ready);
   modport sink   (input valid, input rx_byte, input rx_error, output ready);
endinterface

interface cidp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] char_value;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output kind, output char_value, output status,
                   output last, input ready);
   modport sink   (input valid, input kind, input char_value, input status,
                   input last, output ready);
endinterface

[hw/rtl/caller_id_message_parser_top.sv]
// ----------------------------------------------------------------------------
// Caller-ID message parser
// Parses SDMF/MDMF caller-ID frames from demodulated bytes and reads out the
// captured number, name and frame status.
// ----------------------------------------------------------------------------
// Each received byte is one req transaction; zero bytes are dropped, and a
// transaction with rx_error set ends the frame with a receive-error status.
// The number and the name are written into two RAMs of NUMBER_MAX and
// NAME_MAX characters as the body arrives; longer strings are truncated. A
// good frame is followed by one rsp transaction per stored number character,
// one per stored name character and a closing status transaction (last set).
// The readout sequencer walks the RAM read ports one entry per cycle unless
// a low rsp ready holds it; req ready is low while the readout runs. Bad
// checksum and receive error produce just the status transaction, with no
// gap. There is no clearing pass after reset: only entries below the fill
// counts are ever read.
// ----------------------------------------------------------------------------
module caller_id_message_parser_top #(
   parameter int unsigned NUMBER_MAX = cidp_pkg::NUMBER_MAX_DEF,
   parameter int unsigned NAME_MAX   = cidp_pkg::NAME_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cidp_req_if.sink    req_chan,
   cidp_rsp_if.source  rsp_chan
);

   localparam int unsigned NUM_CW  = $clog2(NUMBER_MAX + 1);
   localparam int unsigned NAME_CW = $clog2(NAME_MAX + 1);
   localparam int unsigned NUM_AW  = (NUMBER_MAX > 1) ? $clog2(NUMBER_MAX) : 1;
   localparam int unsigned NAME_AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam int unsigned IDX_W   = (NUM_CW > NAME_CW) ? NUM_CW : NAME_CW;

   typedef enum logic [3:0] {
      RO_IDLE = 4'b0001,
      RO_NUM  = 4'b0010,
      RO_NAME = 4'b0100,
      RO_STAT = 4'b1000
   } ro_state_type;

   ro_state_type           ro_state_ff, ro_state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in, idx_nx;
   logic [1:0]             stat_ff, stat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             kind_ff, kind_in;
   logic [7:0]             char_ff, char_in;
   logic [1:0]             status_ff, status_in;
   logic                   last_ff, last_in;
   logic                   out_load;
   logic                   can_load;
   logic                   accept;

   logic                   num_we, name_we;
   logic [NUM_AW-1:0]      num_waddr;
   logic [NAME_AW-1:0]     name_waddr;
   logic [7:0]             wr_data;
   logic [NUM_CW-1:0]      number_count;
   logic [NAME_CW-1:0]     name_count;
   logic [7:0]             num_rdata, name_rdata;
   cidp_pkg::cidp_evt_type evt;

   // Input side: take bytes only while no readout runs and the output
   // register is free (or drains this cycle).
   assign can_load       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (ro_state_ff == RO_IDLE) && can_load;
   assign accept         = req_chan.valid && req_chan.ready;

   cidp_parser #(
      .NUMBER_MAX (NUMBER_MAX),
      .NAME_MAX   (NAME_MAX),
      .NUM_CW     (NUM_CW),
      .NAME_CW    (NAME_CW),
      .NUM_AW     (NUM_AW),
      .NAME_AW    (NAME_AW)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_chan.rx_byte),
      .rx_error     (req_chan.rx_error),
      .num_we       (num_we),
      .num_waddr    (num_waddr),
      .name_we      (name_we),
      .name_waddr   (name_waddr),
      .wr_data      (wr_data),
      .number_count (number_count),
      .name_count   (name_count),
      .evt          (evt)
   );

   // Character stores; the read address is the next readout index, so the
   // registered read data always belongs to the current index.
   cidp_ram #(
      .WIDTH  (8),
      .DEPTH  (NUMBER_MAX),
      .ADDR_W (NUM_AW)
   ) u_num_ram (
      .clock      (clock),
      .wr_en      (num_we),
      .wr_addr    (num_waddr),
      .wr_data    (wr_data),
      .rd_addr    (idx_in[NUM_AW-1:0]),
      .rd_data_ff (num_rdata)
   );

   cidp_ram #(
      .WIDTH  (8),
      .DEPTH  (NAME_MAX),
      .ADDR_W (NAME_AW)
   ) u_name_ram (
      .clock      (clock),
      .wr_en      (name_we),
      .wr_addr    (name_waddr),
      .wr_data    (wr_data),
      .rd_addr    (idx_in[NAME_AW-1:0]),
      .rd_data_ff (name_rdata)
   );

   assign idx_nx = idx_ff + IDX_W'(1);

   // Readout sequencer and output register
   always_comb begin
      ro_state_in = ro_state_ff;
      idx_in      = idx_ff;
      stat_in     = stat_ff;
      out_load    = 1'b0;
      kind_in     = kind_ff;
      char_in     = char_ff;
      status_in   = status_ff;
      last_in     = last_ff;

      unique case (ro_state_ff)
         RO_IDLE: begin
            if (evt.fire && evt.good) begin
               // start readout at entry zero; skip empty stores
               idx_in  = '0;
               stat_in = evt.status;
               if (number_count != '0) begin
                  ro_state_in = RO_NUM;
               end else if (name_count != '0) begin
                  ro_state_in = RO_NAME;
               end else begin
                  ro_state_in = RO_STAT;
               end
            end else if (evt.fire) begin
               // bad checksum or receive error: status only
               out_load  = 1'b1;
               kind_in   = cidp_pkg::KIND_STATUS;
               char_in   = 8'd0;
               status_in = evt.status;
               last_in   = 1'b1;
            end
         end
         RO_NUM: begin
            if (can_load) begin
               out_load  = 1'b1;
               kind_in   = cidp_pkg::KIND_NUMBER;
               char_in   = num_rdata;
               status_in = cidp_pkg::ST_GOOD_MDMF;
               last_in   = 1'b0;
               if (idx_nx == IDX_W'(number_count)) begin
                  idx_in      = '0;
                  ro_state_in = (name_count != '0) ? RO_NAME : RO_STAT;
               end else begin
                  idx_in = idx_nx;
               end
            end
         end
         RO_NAME: begin
            if (can_load) begin
               out_load  = 1'b1;
               kind_in   = cidp_pkg::KIND_NAME;
               char_in   = name_rdata;
               status_in = cidp_pkg::ST_GOOD_MDMF;
               last_in   = 1'b0;
               if (idx_nx == IDX_W'(name_count)) begin
                  idx_in      = '0;
                  ro_state_in = RO_STAT;
               end else begin
                  idx_in = idx_nx;
               end
            end
         end
         RO_STAT: begin
            if (can_load) begin
               out_load    = 1'b1;
               kind_in     = cidp_pkg::KIND_STATUS;
               char_in     = 8'd0;
               status_in   = stat_ff;
               last_in     = 1'b1;
               ro_state_in = RO_IDLE;
            end
         end
         default: ro_state_in = RO_IDLE;
      endcase

      // hold the output until taken, advance on load
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ro_state_ff  <= RO_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ro_state_ff  <= ro_state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff   <= stat_in;
      kind_ff   <= kind_in;
      char_ff   <= char_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = kind_ff;
   assign rsp_chan.char_value = char_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.last       = last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // no byte transaction may slip in while the stores are read out
   a_no_accept_in_readout : assert property (@(posedge clock) disable iff (reset)
      (ro_state_ff != RO_IDLE) |-> !req_chan.ready)
      else $error("byte taken during readout");

   // fill counts never pass the store sizes
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (number_count <= NUM_CW'(NUMBER_MAX)) && (name_count <= NAME_CW'(NAME_MAX)))
      else $error("store fill count beyond store size");

   // character results never close a run and carry a zero status
   a_char_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind != cidp_pkg::KIND_STATUS))
         |-> (!rsp_chan.last && (rsp_chan.status == cidp_pkg::ST_GOOD_MDMF)))
      else $error("character result with last or status set");

   // the readout always ends in the status result before new bytes are taken
   a_stat_then_idle : assert property (@(posedge clock) disable iff (reset)
      ((ro_state_ff == RO_STAT) && can_load) |=> (ro_state_ff == RO_IDLE) && rsp_chan.last)
      else $error("readout did not close with status");

endmodule

[hw/rtl/cidp_ram.sv]
// ----------------------------------------------------------------------------
// Caller-ID parser RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cidp_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 24,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

[hw/rtl/cidp_parser.sv]
// ----------------------------------------------------------------------------
// Caller-ID frame parser
// Byte-level framing state machine, checksum and MDMF parameter tracking;
// drives the store write ports and flags the end of each frame.
// ----------------------------------------------------------------------------
module cidp_parser #(
   parameter int unsigned NUMBER_MAX = cidp_pkg::NUMBER_MAX_DEF,
   parameter int unsigned NAME_MAX   = cidp_pkg::NAME_MAX_DEF,
   parameter int unsigned NUM_CW     = $clog2(NUMBER_MAX + 1),
   parameter int unsigned NAME_CW    = $clog2(NAME_MAX + 1),
   parameter int unsigned NUM_AW     = (NUMBER_MAX > 1) ? $clog2(NUMBER_MAX) : 1,
   parameter int unsigned NAME_AW    = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   input  logic                  rx_error,
   output logic                  num_we,
   output logic [NUM_AW-1:0]     num_waddr,
   output logic                  name_we,
   output logic [NAME_AW-1:0]    name_waddr,
   output logic [7:0]            wr_data,
   output logic [NUM_CW-1:0]     number_count,
   output logic [NAME_CW-1:0]    name_count,
   output cidp_pkg::cidp_evt_type evt
);

   typedef enum logic [4:0] {
      PH_HUNT   = 5'b00001,
      PH_LEADIN = 5'b00010,
      PH_LENGTH = 5'b00100,
      PH_BODY   = 5'b01000,
      PH_CHECK  = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      PP_TYPE = 3'b001,
      PP_LEN  = 3'b010,
      PP_DATA = 3'b100
   } pphase_type;

   typedef enum logic [1:0] {
      CL_NONE   = 2'd0,
      CL_NUMBER = 2'd1,
      CL_NAME   = 2'd2
   } class_type;

   phase_type          phase_ff, phase_in;
   pphase_type         pp_ff, pp_in;
   class_type          pc_ff, pc_in;
   logic               mdmf_ff, mdmf_in;
   logic [7:0]         blen_ff, blen_in;
   logic [7:0]         bcnt_ff, bcnt_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         pleft_ff, pleft_in;
   logic [NUM_CW-1:0]  ncnt_ff, ncnt_in;
   logic [NAME_CW-1:0] acnt_ff, acnt_in;
   class_type          store_cls, clear_cls;
   logic [7:0]         chk_sum;

   assign chk_sum = sum_ff + rx_byte;

   always_comb begin
      phase_in  = phase_ff;
      pp_in     = pp_ff;
      pc_in     = pc_ff;
      mdmf_in   = mdmf_ff;
      blen_in   = blen_ff;
      bcnt_in   = bcnt_ff;
      sum_in    = sum_ff;
      pleft_in  = pleft_ff;
      ncnt_in   = ncnt_ff;
      acnt_in   = acnt_ff;
      store_cls = CL_NONE;
      clear_cls = CL_NONE;
      num_we    = 1'b0;
      name_we   = 1'b0;
      evt       = '0;

      if (accept && rx_error) begin
         phase_in   = PH_HUNT;
         evt.fire   = 1'b1;
         evt.status = cidp_pkg::ST_RX_ERR;
      end else if (accept && (rx_byte != 8'd0)) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == cidp_pkg::FLAG_BYTE) begin
                  phase_in = PH_LEADIN;
               end
            end
            PH_LEADIN: begin
               if ((rx_byte == cidp_pkg::LEADIN_SDMF) ||
                   (rx_byte == cidp_pkg::LEADIN_MDMF)) begin
                  mdmf_in  = (rx_byte == cidp_pkg::LEADIN_MDMF);
                  sum_in   = rx_byte;
                  ncnt_in  = '0;
                  acnt_in  = '0;
                  pp_in    = PP_TYPE;
                  pc_in    = CL_NONE;
                  pleft_in = 8'd0;
                  bcnt_in  = 8'd0;
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               blen_in  = rx_byte;
               sum_in   = chk_sum;
               phase_in = (rx_byte == 8'd0) ? PH_CHECK : PH_BODY;
            end
            PH_BODY: begin
               sum_in  = chk_sum;
               bcnt_in = bcnt_ff + 8'd1;
               if (!mdmf_ff) begin
                  if (bcnt_ff >= cidp_pkg::SDMF_NUMBER_START) begin
                     store_cls = CL_NUMBER;
                  end
               end else begin
                  unique case (pp_ff)
                     PP_TYPE: begin
                        if ((rx_byte == cidp_pkg::PARAM_NUMBER_A) ||
                            (rx_byte == cidp_pkg::PARAM_NUMBER_B)) begin
                           pc_in = CL_NUMBER;
                        end else if ((rx_byte == cidp_pkg::PARAM_NAME_A) ||
                                     (rx_byte == cidp_pkg::PARAM_NAME_B)) begin
                           pc_in = CL_NAME;
                        end else begin
                           pc_in = CL_NONE;
                        end
                        pp_in = PP_LEN;
                     end
                     PP_LEN: begin
                        clear_cls = pc_ff;
                        pleft_in  = rx_byte;
                        pp_in     = (rx_byte == 8'd0) ? PP_TYPE : PP_DATA;
                     end
                     PP_DATA: begin
                        store_cls = pc_ff;
                        pleft_in  = pleft_ff - 8'd1;
                        if (pleft_in == 8'd0) begin
                           pp_in = PP_TYPE;
                        end
                     end
                     default: pp_in = PP_TYPE;
                  endcase
               end
               if (bcnt_in == blen_ff) begin
                  // type byte closing the body: its parameter counts as empty
                  if (mdmf_ff && (pp_in == PP_LEN)) begin
                     clear_cls = pc_in;
                  end
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               phase_in = PH_HUNT;
               evt.fire = 1'b1;
               evt.good = (chk_sum == 8'd0);
               if (chk_sum != 8'd0) begin
                  evt.status = cidp_pkg::ST_BAD_SUM;
               end else begin
                  evt.status = mdmf_ff ? cidp_pkg::ST_GOOD_MDMF : cidp_pkg::ST_GOOD_SDMF;
               end
            end
            default: phase_in = PH_HUNT;
         endcase

         case (clear_cls)
            CL_NUMBER: ncnt_in = '0;
            CL_NAME:   acnt_in = '0;
            default:   ;
         endcase

         // drop characters once a store is full
         case (store_cls)
            CL_NUMBER: begin
               if (ncnt_ff < NUM_CW'(NUMBER_MAX)) begin
                  num_we  = 1'b1;
                  ncnt_in = ncnt_ff + NUM_CW'(1);
               end
            end
            CL_NAME: begin
               if (acnt_ff < NAME_CW'(NAME_MAX)) begin
                  name_we = 1'b1;
                  acnt_in = acnt_ff + NAME_CW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pp_ff    <= PP_TYPE;
         pc_ff    <= CL_NONE;
         mdmf_ff  <= 1'b0;
         blen_ff  <= 8'd0;
         bcnt_ff  <= 8'd0;
         sum_ff   <= 8'd0;
         pleft_ff <= 8'd0;
         ncnt_ff  <= '0;
         acnt_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pp_ff    <= pp_in;
         pc_ff    <= pc_in;
         mdmf_ff  <= mdmf_in;
         blen_ff  <= blen_in;
         bcnt_ff  <= bcnt_in;
         sum_ff   <= sum_in;
         pleft_ff <= pleft_in;
         ncnt_ff  <= ncnt_in;
         acnt_ff  <= acnt_in;
      end
   end

   assign num_waddr    = ncnt_ff[NUM_AW-1:0];
   assign name_waddr   = acnt_ff[NAME_AW-1:0];
   assign wr_data      = rx_byte;
   assign number_count = ncnt_ff;
   assign name_count   = acnt_ff;

endmodule
